@@ rtl/core/hsfe_pkg.sv @@
// ----------------------------------------------------------------------------
// hsfe_pkg
// Shared types and constants of the HDLC-style frame encoder.
// ----------------------------------------------------------------------------
package hsfe_pkg;

    localparam logic [7:0] FLAG_BYTE  = 8'h7E;
    localparam logic [7:0] ESC_BYTE   = 8'h7D;
    localparam logic [7:0] ADDR_BYTE  = 8'h03;
    localparam logic [7:0] CTRL_SEQ0  = 8'h00;
    localparam logic [7:0] CTRL_SEQ1  = 8'h02;
    localparam logic [7:0] STUFF_MASK = 8'h20;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // One classified payload byte, handed from the front to the back
    typedef struct packed {
        logic [7:0] data;      // raw payload byte
        logic       data_esc;  // payload byte needs stuffing
        logic       hdr;       // emit the header first
        logic       seq;       // sequence bit of the frame
        logic       last;      // close the frame after this byte
        logic [7:0] chk;       // check byte, valid when last is set
        logic       chk_esc;   // check byte needs stuffing
    } cmd_t;

    localparam int CMD_W = $bits(cmd_t);

    function automatic logic needs_stuff(input logic [7:0] b);
        needs_stuff = (b == FLAG_BYTE) || (b == ESC_BYTE);
    endfunction

endpackage

@@ rtl/core/hsfe_front.sv @@
// ----------------------------------------------------------------------------
// hsfe_front
// Accepts payload bytes, tracks frame state and the running check, and
// classifies each byte into a command for the back end.
// ----------------------------------------------------------------------------
module hsfe_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [7:0]          in_data,
    input  logic                in_last,
    input  logic                queue_full,
    output logic                in_ready,
    output logic                push,
    output hsfe_pkg::cmd_t      cmd
);

    logic       seq_reg;
    logic       seq_next;
    logic       open_reg;
    logic       open_next;
    logic [7:0] acc_reg;
    logic [7:0] acc_next;
    logic [7:0] acc_base;
    logic [7:0] chk;

    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full;

    // A new frame starts its check from zero
    assign acc_base = open_reg ? acc_reg : 8'h00;
    assign chk      = acc_base ^ in_data;

    always_comb
    begin
        cmd.data     = in_data;
        cmd.data_esc = hsfe_pkg::needs_stuff(in_data);
        cmd.hdr      = !open_reg;
        cmd.seq      = seq_reg;
        cmd.last     = in_last;
        cmd.chk      = chk;
        cmd.chk_esc  = hsfe_pkg::needs_stuff(chk);
    end

    always_comb
    begin
        seq_next  = seq_reg;
        open_next = open_reg;
        acc_next  = acc_reg;
        if (push)
        begin
            if (in_last)
            begin
                seq_next  = !seq_reg;
                open_next = 1'b0;
                acc_next  = 8'h00;
            end
            else
            begin
                open_next = 1'b1;
                acc_next  = chk;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg  <= 1'b0;
            open_reg <= 1'b0;
            acc_reg  <= 8'h00;
        end
        else
        begin
            seq_reg  <= seq_next;
            open_reg <= open_next;
            acc_reg  <= acc_next;
        end
    end

endmodule

@@ rtl/core/hsfe_queue.sv @@
// ----------------------------------------------------------------------------
// hsfe_queue
// Small register FIFO between the front and back ends.
// ----------------------------------------------------------------------------
module hsfe_queue
#(
    parameter int WIDTH = hsfe_pkg::CMD_W,
    parameter int DEPTH = hsfe_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty,
    output logic             full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             do_push;
    logic             do_pop;

    assign empty   = (cnt_reg == '0);
    assign full    = (cnt_reg == FULL_CNT);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

@@ rtl/core/hsfe_back.sv @@
// ----------------------------------------------------------------------------
// hsfe_back
// Steps through the line bytes of each queued command and drives the
// output register, one byte per cycle while the receiver does not stall.
// ----------------------------------------------------------------------------
module hsfe_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  hsfe_pkg::cmd_t cmd,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     out_byte,
    output logic           out_last,
    output logic           out_done
);

    localparam logic [3:0] ST_FLAG0 = 4'd0;
    localparam logic [3:0] ST_ADDR  = 4'd1;
    localparam logic [3:0] ST_CTRL  = 4'd2;
    localparam logic [3:0] ST_HCHK  = 4'd3;
    localparam logic [3:0] ST_DESC  = 4'd4;
    localparam logic [3:0] ST_DATA  = 4'd5;
    localparam logic [3:0] ST_CESC  = 4'd6;
    localparam logic [3:0] ST_CHK   = 4'd7;
    localparam logic [3:0] ST_FLAG1 = 4'd8;

    logic [3:0] step_reg;
    logic [3:0] step_next;
    logic       first_reg;
    logic       first_next;
    logic [3:0] step;
    logic [3:0] data_step;
    logic [3:0] nxt;
    logic       final_step;
    logic [7:0] ctrl;
    logic [7:0] byte_val;
    logic       load;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       done_reg;

    assign data_step = cmd.data_esc ? ST_DESC : ST_DATA;
    assign step      = first_reg ? (cmd.hdr ? ST_FLAG0 : data_step) : step_reg;
    assign ctrl      = cmd.seq ? hsfe_pkg::CTRL_SEQ1 : hsfe_pkg::CTRL_SEQ0;
    assign load      = cmd_valid && (!valid_reg || out_ready);
    assign pop       = load && final_step;

    always_comb
    begin
        byte_val   = hsfe_pkg::FLAG_BYTE;
        nxt        = ST_FLAG0;
        final_step = 1'b0;
        unique case (step)
            ST_FLAG0:
            begin
                byte_val = hsfe_pkg::FLAG_BYTE;
                nxt      = ST_ADDR;
            end
            ST_ADDR:
            begin
                byte_val = hsfe_pkg::ADDR_BYTE;
                nxt      = ST_CTRL;
            end
            ST_CTRL:
            begin
                byte_val = ctrl;
                nxt      = ST_HCHK;
            end
            ST_HCHK:
            begin
                byte_val = hsfe_pkg::ADDR_BYTE ^ ctrl;
                nxt      = data_step;
            end
            ST_DESC:
            begin
                byte_val = hsfe_pkg::ESC_BYTE;
                nxt      = ST_DATA;
            end
            ST_DATA:
            begin
                byte_val   = cmd.data_esc ? (cmd.data ^ hsfe_pkg::STUFF_MASK) : cmd.data;
                nxt        = cmd.chk_esc ? ST_CESC : ST_CHK;
                final_step = !cmd.last;
            end
            ST_CESC:
            begin
                byte_val = hsfe_pkg::ESC_BYTE;
                nxt      = ST_CHK;
            end
            ST_CHK:
            begin
                byte_val = cmd.chk_esc ? (cmd.chk ^ hsfe_pkg::STUFF_MASK) : cmd.chk;
                nxt      = ST_FLAG1;
            end
            ST_FLAG1:
            begin
                byte_val   = hsfe_pkg::FLAG_BYTE;
                final_step = 1'b1;
            end
            default:
            begin
                byte_val   = hsfe_pkg::FLAG_BYTE;
                final_step = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        step_next  = step_reg;
        first_next = first_reg;
        valid_next = valid_reg;
        if (out_ready)
            valid_next = 1'b0;
        if (load)
        begin
            valid_next = 1'b1;
            if (final_step)
                first_next = 1'b1;
            else
            begin
                first_next = 1'b0;
                step_next  = nxt;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= ST_FLAG0;
            first_reg <= 1'b1;
            valid_reg <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            first_reg <= first_next;
            valid_reg <= valid_next;
        end
    end

    // Hold the payload while the receiver stalls
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= byte_val;
            last_reg <= final_step;
            done_reg <= (step == ST_FLAG1);
        end
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;
    assign out_done  = done_reg;

endmodule

@@ rtl/core/hdlc_style_frame_encoder.sv @@
// ----------------------------------------------------------------------------
// hdlc_style_frame_encoder
// Builds HDLC-style information frames with byte stuffing from payload bytes.
// ----------------------------------------------------------------------------
// Slave stream: one payload byte per transfer in s_tdata, s_tlast on the
// final byte of a frame. Master stream: one line byte per transfer in
// m_tdata; m_tlast marks the final line byte caused by a payload byte and
// m_tuser flags the closing flag of a frame.
// The first byte of a frame brings out the four header bytes, every byte
// goes out stuffed (one or two line bytes), and the last byte adds the
// stuffed check byte and the closing flag. One payload byte therefore
// costs 1 to 9 line bytes, and the output port emits one line byte per
// cycle while m_tready holds; an unstuffed middle byte takes one line
// byte, a stuffed one two. The front end takes a payload byte in any cycle
// the command queue has room (QUEUE_DEPTH entries), so input transfers run
// back to back while the output drains. The first line byte of a transfer
// is written to the command queue, then loaded into the output register,
// before it is offered on m_tdata. When the receiver stalls, the output
// register holds its byte, the queue fills and s_tready drops. Reset clears
// the frame state, sequence bit, check and queue; no frame is open after.
// ----------------------------------------------------------------------------
module hdlc_style_frame_encoder
#(
    parameter int QUEUE_DEPTH = hsfe_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] payload_byte
    input  logic       s_tlast,   // is_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] line_byte
    output logic       m_tlast,   // run_last
    output logic [0:0] m_tuser    // [0] frame_done
);

    hsfe_pkg::cmd_t front_cmd;
    hsfe_pkg::cmd_t head_cmd;
    logic           push;
    logic           pop;
    logic           q_empty;
    logic           q_full;
    logic           done;

    hsfe_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_data    (s_tdata),
        .in_last    (s_tlast),
        .queue_full (q_full),
        .in_ready   (s_tready),
        .push       (push),
        .cmd        (front_cmd)
    );

    hsfe_queue
    #(
        .WIDTH (hsfe_pkg::CMD_W),
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (front_cmd),
        .pop     (pop),
        .rd_data (head_cmd),
        .empty   (q_empty),
        .full    (q_full)
    );

    hsfe_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!q_empty),
        .cmd       (head_cmd),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .out_last  (m_tlast),
        .out_done  (done)
    );

    assign m_tuser = done;

endmodule
